// ===== rtl/awnfa_pkg.sv =====
// shared types and constants for the adaptive window noise floor averager
// no dependencies
package awnfa_pkg;

   localparam int RING_DEPTH    = 128;
   localparam int RING_AW       = $clog2(RING_DEPTH);
   localparam int FILL_BITS     = RING_AW + 1;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int EST_BITS      = 24;
   localparam int ITER_BITS     = 7;
   localparam int WIN_BITS      = 8;
   localparam int SUM_BITS      = 24;
   localparam int MUL_BITS      = 32;
   localparam int DVD_BITS      = 32;
   localparam int DVR_BITS      = 16;
   localparam int DIV_CNT_BITS  = $clog2(DVD_BITS + 1);
   localparam int CSR_AW        = 4;
   localparam int CSR_DW        = 32;

   localparam logic [DVD_BITS-1:0] EST_MAG_LIMIT = DVD_BITS'(1) << (EST_BITS - 1);

   // register indexes
   localparam logic [1:0] REG_NOISE_SIGMA = 2'd0;
   localparam logic [1:0] REG_UNIT_SCALE  = 2'd1;
   localparam logic [1:0] REG_WINDOW_MIN  = 2'd2;
   localparam logic [1:0] REG_WINDOW_MAX  = 2'd3;

   typedef struct packed {
      logic [15:0]         noise_sigma;
      logic [15:0]         unit_scale;
      logic [WIN_BITS-1:0] window_min;
      logic [WIN_BITS-1:0] window_max;
   } cfg_type;

endpackage

// ===== rtl/awnfa_csr.sv =====
// configuration register file, apb-style write and read
// depends on awnfa_pkg
module awnfa_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [awnfa_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [awnfa_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [awnfa_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output awnfa_pkg::cfg_type         cfg
);
   import awnfa_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NOISE_SIGMA: cfg_in.noise_sigma = csr_pwdata[15:0];
            REG_UNIT_SCALE:  cfg_in.unit_scale  = csr_pwdata[15:0];
            REG_WINDOW_MIN:  cfg_in.window_min  = csr_pwdata[WIN_BITS-1:0];
            REG_WINDOW_MAX:  cfg_in.window_max  = csr_pwdata[WIN_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_sigma <= 16'd20;
         cfg_ff.unit_scale  <= 16'd4096;
         cfg_ff.window_min  <= WIN_BITS'(4);
         cfg_ff.window_max  <= WIN_BITS'(128);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NOISE_SIGMA: csr_prdata = {16'd0, cfg_ff.noise_sigma};
         REG_UNIT_SCALE:  csr_prdata = {16'd0, cfg_ff.unit_scale};
         REG_WINDOW_MIN:  csr_prdata = {(CSR_DW-WIN_BITS)'(0), cfg_ff.window_min};
         REG_WINDOW_MAX:  csr_prdata = {(CSR_DW-WIN_BITS)'(0), cfg_ff.window_max};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/awnfa_mul.sv =====
// shared signed multiplier with registered product
// depends on awnfa_pkg
module awnfa_mul (
   input  logic                                 clock,
   input  logic signed [awnfa_pkg::MUL_BITS-1:0] op_a,
   input  logic signed [awnfa_pkg::MUL_BITS-1:0] op_b,
   output logic signed [2*awnfa_pkg::MUL_BITS-1:0] prod
);
   import awnfa_pkg::*;

   logic signed [2*MUL_BITS-1:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/awnfa_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on awnfa_pkg
module awnfa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [awnfa_pkg::DVD_BITS-1:0] dividend,
   input  logic [awnfa_pkg::DVR_BITS-1:0] divisor,
   output logic                          done,
   output logic [awnfa_pkg::DVD_BITS-1:0] quotient
);
   import awnfa_pkg::*;

   logic [DVD_BITS-1:0]     dvd_ff, dvd_in;
   logic [DVR_BITS-1:0]     dvr_ff, dvr_in;
   logic [DVR_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DVR_BITS:0]       rem_sh;
   logic [DVR_BITS:0]       rem_sub;
   logic                    q_bit;

   assign rem_sh  = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, dvr_ff};
   assign q_bit   = (rem_sh >= {1'b0, dvr_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      dvr_in  = dvr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvr_in  = divisor;
         rem_in  = '0;
         cnt_in  = DIV_CNT_BITS'(DVD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_BITS-2:0], q_bit};
         rem_in = q_bit ? rem_sub[DVR_BITS-1:0] : rem_sh[DVR_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvr_ff <= dvr_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/adaptive_window_noise_floor_average_top.sv =====
// top level of the adaptive window noise floor averager: sequencer, sample ring
// depends on awnfa_pkg, awnfa_csr, awnfa_mul, awnfa_div
//
// each request pushes one signed sample into a 128 entry ring. the step to the
// previous sample picks a window n (unit_scale / |step|, clamped to window_min,
// window_max and the fill count; window_max on a zero step), then a running mean
// grows over the newest samples until it settles inside the noise floor set by
// noise_sigma. all arithmetic runs through one shared 32x32 multiplier and one
// bit-serial divider under a one-hot sequencer; req_ready is low while a request
// is worked. a request runs the window division (skipped on a zero step), the
// growth steps through the multiplier and a rounding division of the mean; a lone
// first sample skips the window and the growth. the result is held in an output
// register, and a later request only waits there if the previous result has not
// been taken. no clearing pass at reset.
module adaptive_window_noise_floor_average_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [awnfa_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [awnfa_pkg::EST_BITS-1:0]    rsp_estimate,
   output logic [awnfa_pkg::ITER_BITS-1:0]          rsp_iterations_used,
   output logic [awnfa_pkg::WIN_BITS-1:0]           rsp_saved_iterations,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [awnfa_pkg::CSR_AW-1:0]             csr_paddr,
   input  logic [awnfa_pkg::CSR_DW-1:0]             csr_pwdata,
   output logic [awnfa_pkg::CSR_DW-1:0]             csr_prdata,
   output logic                                csr_pready
);
   import awnfa_pkg::*;

   // one-hot sequencer
   typedef enum logic [17:0] {
      ST_IDLE  = 18'b000000000000000001,
      ST_RD1   = 18'b000000000000000010,
      ST_DIFF  = 18'b000000000000000100,
      ST_DIVW  = 18'b000000000000001000,
      ST_CLAMP = 18'b000000000000010000,
      ST_LOOP  = 18'b000000000000100000,
      ST_RD    = 18'b000000000001000000,
      ST_MX    = 18'b000000000010000000,
      ST_NUM   = 18'b000000000100000000,
      ST_AN    = 18'b000000001000000000,
      ST_AAN   = 18'b000000010000000000,
      ST_SW    = 18'b000000100000000000,
      ST_SR    = 18'b000001000000000000,
      ST_RR    = 18'b000010000000000000,
      ST_CMP   = 18'b000100000000000000,
      ST_MEAN  = 18'b001000000000000000,
      ST_DIVM  = 18'b010000000000000000,
      ST_DONE  = 18'b100000000000000000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;

   // sample ring
   logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [RING_AW-1:0]            rd_addr;
   logic [RING_AW-1:0]            wp_ff, wp_in;
   logic [FILL_BITS-1:0]          fill_ff, fill_in;
   logic                          req_fire;

   // working registers
   logic signed [SAMPLE_BITS-1:0] s0_ff, s0_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SUM_BITS-1:0]           a_ff, a_in;
   logic [WIN_BITS-1:0]           w_ff, w_in;
   logic [WIN_BITS-1:0]           n_ff, n_in;
   logic [ITER_BITS-1:0]          iters_ff, iters_in;
   logic [15:0]                   nn_ff, nn_in;
   logic [2*MUL_BITS-1:0]         lhs_ff, lhs_in;
   logic                          neg_ff, neg_in;
   logic signed [EST_BITS-1:0]    est_ff, est_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [EST_BITS-1:0]    rsp_est_ff, rsp_est_in;
   logic [ITER_BITS-1:0]          rsp_iters_ff, rsp_iters_in;
   logic [WIN_BITS-1:0]           rsp_saved_ff, rsp_saved_in;

   // shared units
   logic signed [MUL_BITS-1:0]    mul_a, mul_b;
   logic signed [2*MUL_BITS-1:0]  mul_p;
   logic                          div_start;
   logic [DVD_BITS-1:0]           div_dvd;
   logic [DVR_BITS-1:0]           div_dvr;
   logic                          div_done;
   logic [DVD_BITS-1:0]           div_q;

   // combinational helpers
   logic signed [SAMPLE_BITS:0]   step_d;
   logic [SAMPLE_BITS-1:0]        step_abs;
   logic signed [SUM_BITS:0]      num;
   logic [SUM_BITS-1:0]           sum_mag;
   logic [15:0]                   nn_lo, nn_hi, nn_fill;
   logic [DVD_BITS-1:0]           q_sat;
   logic signed [DVD_BITS:0]      est_wide;
   logic [WIN_BITS-1:0]           iters_ext;

   awnfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   awnfa_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   awnfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvr),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;

   // ring_at(lag) sits at wp - 1 - lag; w holds lag + 1
   assign rd_addr = wp_ff - w_ff[RING_AW-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ring_mem[wp_ff] <= req_sample;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign step_d   = {s0_ff[SAMPLE_BITS-1], s0_ff} - {rd_data_ff[SAMPLE_BITS-1], rd_data_ff};
   assign step_abs = step_d[SAMPLE_BITS] ? SAMPLE_BITS'(-step_d) : step_d[SAMPLE_BITS-1:0];

   assign num = mul_p[SUM_BITS:0] - {sum_ff[SUM_BITS-1], sum_ff};

   assign sum_mag = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : sum_ff;

   // window clamp: min, then max, then fill count
   assign nn_lo   = (nn_ff < {8'd0, cfg.window_min}) ? {8'd0, cfg.window_min} : nn_ff;
   assign nn_hi   = (nn_lo > {8'd0, cfg.window_max}) ? {8'd0, cfg.window_max} : nn_lo;
   assign nn_fill = (nn_hi > {(16-FILL_BITS)'(0), fill_ff}) ?
                    {(16-FILL_BITS)'(0), fill_ff} : nn_hi;

   // rounding result: saturate magnitude, apply sign, clamp
   assign q_sat    = (div_q > EST_MAG_LIMIT) ? EST_MAG_LIMIT : div_q;
   assign est_wide = neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

   assign iters_ext = {1'b0, iters_ff};

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      s0_in        = s0_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      a_in         = a_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      iters_in     = iters_ff;
      nn_in        = nn_ff;
      lhs_in       = lhs_ff;
      neg_in       = neg_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_est_in   = rsp_est_ff;
      rsp_iters_in = rsp_iters_ff;
      rsp_saved_in = rsp_saved_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wp_in    = wp_ff + 1'b1;
               fill_in  = (fill_ff < FILL_BITS'(RING_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
               s0_in    = req_sample;
               w_in     = WIN_BITS'(2);
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // previous sample is read here
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (fill_ff < FILL_BITS'(2)) begin
               // lone sample: mean of one, no window
               sum_in   = SUM_BITS'(s0_ff);
               w_in     = WIN_BITS'(1);
               n_in     = '0;
               iters_in = '0;
               state_in = ST_MEAN;
            end else if (step_abs == '0) begin
               nn_in    = {8'd0, cfg.window_max};
               state_in = ST_CLAMP;
            end else begin
               div_start = 1'b1;
               div_dvd   = {(DVD_BITS-16)'(0), cfg.unit_scale};
               div_dvr   = DVR_BITS'(step_abs);
               state_in  = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               nn_in    = div_q[15:0];
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            n_in     = nn_fill[WIN_BITS-1:0];
            sum_in   = SUM_BITS'(s0_ff);
            w_in     = WIN_BITS'(1);
            iters_in = '0;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (w_ff < n_ff) begin
               w_in     = w_ff + 1'b1;
               state_in = ST_RD;
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_RD: begin
            state_in = ST_MX;
         end
         ST_MX: begin
            // x * (w - 1)
            x_in     = rd_data_ff;
            mul_a    = MUL_BITS'(rd_data_ff);
            mul_b    = $signed({(MUL_BITS-WIN_BITS)'(0), w_ff - 1'b1});
            state_in = ST_NUM;
         end
         ST_NUM: begin
            a_in     = num[SUM_BITS] ? SUM_BITS'(-num) : num[SUM_BITS-1:0];
            sum_in   = sum_ff + SUM_BITS'(x_ff);
            state_in = ST_AN;
         end
         ST_AN: begin
            mul_a    = $signed({(MUL_BITS-SUM_BITS)'(0), a_ff});
            mul_b    = $signed({(MUL_BITS-WIN_BITS)'(0), n_ff});
            state_in = ST_AAN;
         end
         ST_AAN: begin
            mul_a    = mul_p[MUL_BITS-1:0];
            mul_b    = $signed({(MUL_BITS-SUM_BITS)'(0), a_ff});
            state_in = ST_SW;
         end
         ST_SW: begin
            lhs_in   = mul_p;
            mul_a    = $signed({(MUL_BITS-16)'(0), cfg.noise_sigma});
            mul_b    = $signed({(MUL_BITS-WIN_BITS)'(0), w_ff});
            state_in = ST_SR;
         end
         ST_SR: begin
            mul_a    = mul_p[MUL_BITS-1:0];
            mul_b    = $signed({(MUL_BITS-WIN_BITS)'(0), w_ff - 1'b1});
            state_in = ST_RR;
         end
         ST_RR: begin
            mul_a    = mul_p[MUL_BITS-1:0];
            mul_b    = mul_p[MUL_BITS-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // stop once diff^2 * n < (sigma * w * (w-1))^2
            iters_in = iters_ff + 1'b1;
            state_in = (lhs_ff < mul_p) ? ST_MEAN : ST_LOOP;
         end
         ST_MEAN: begin
            neg_in    = sum_ff[SUM_BITS-1];
            div_start = 1'b1;
            div_dvd   = {sum_mag[DVD_BITS-FRACTION_BITS-2:0], (FRACTION_BITS+1)'(0)}
                        + DVD_BITS'(w_ff);
            div_dvr   = DVR_BITS'({w_ff, 1'b0});
            state_in  = ST_DIVM;
         end
         ST_DIVM: begin
            if (div_done) begin
               est_in   = EST_BITS'(est_wide);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ff;
               rsp_iters_in = iters_ff;
               rsp_saved_in = (n_ff > iters_ext) ? n_ff - iters_ext : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s0_ff        <= s0_in;
      x_ff         <= x_in;
      sum_ff       <= sum_in;
      a_ff         <= a_in;
      w_ff         <= w_in;
      n_ff         <= n_in;
      iters_ff     <= iters_in;
      nn_ff        <= nn_in;
      lhs_ff       <= lhs_in;
      neg_ff       <= neg_in;
      est_ff       <= est_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_iters_ff <= rsp_iters_in;
      rsp_saved_ff <= rsp_saved_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_estimate         = rsp_est_ff;
   assign rsp_iterations_used  = rsp_iters_ff;
   assign rsp_saved_iterations = rsp_saved_ff;

`ifndef NO_ASSERTIONS
   // fill count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(RING_DEPTH))
      else $error("fill count above ring depth");

   // each growth step adds exactly one iteration
   a_iter_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (iters_ext == w_ff - 1'b1))
      else $error("iteration count out of step with window");

   // window never reaches past the filled part of the ring
   a_window_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> ({1'b0, n_ff} <= {(WIN_BITS+1-FILL_BITS)'(0), fill_ff}))
      else $error("window larger than fill count");

   // a result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result left before output register freed");
`endif

endmodule

// ===== bench/tb.sv =====
// self-checking bench for adaptive_window_noise_floor_average_top
// depends on awnfa_pkg and the top level rtl; drives requests, csr writes, checks results
`timescale 1ns / 1ps

module tb;
   import awnfa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 60;     // settle time after the last result
   localparam int HOLD_CYCLES = 4000;     // long receiver hold-off
   localparam int HOLD_AT = 300;          // result count that triggers the hold-off

   typedef struct {
      logic signed [EST_BITS-1:0] estimate;
      logic [ITER_BITS-1:0]       used;
      logic [WIN_BITS-1:0]        saved;
   } average_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [EST_BITS-1:0] rsp_estimate;
   logic [ITER_BITS-1:0] rsp_iterations_used;
   logic [WIN_BITS-1:0] rsp_saved_iterations;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   adaptive_window_noise_floor_average_top DUT (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // samples waiting to be offered, and averages waiting to come back
   logic signed [SAMPLE_BITS-1:0] pending_samples[$];
   average_result_type expected_averages[$];

   // predictor state: its own copy of ring, pointers and registers
   longint sample_hist[RING_DEPTH];
   int unsigned hist_wr, hist_fill;
   int unsigned sigma_reg, scale_reg, win_lo_reg, win_hi_reg;

   int errors = 0;
   int results_seen = 0;
   int requests_sent = 0;
   int unsigned cycle_count = 0;
   bit req_fire = 1'b0;
   int signed drift_level = 0;

   // no idling on either side while this many results are between these marks
   wire quiet_stretch = (results_seen >= 100) && (results_seen < 200);

   function automatic longint hist_at(int unsigned lag);
      return sample_hist[(hist_wr + RING_DEPTH - 1 - lag) % RING_DEPTH];
   endfunction

   // mean * 256, rounded half away from zero, saturated to 24 bits
   function automatic logic signed [EST_BITS-1:0] rounded_mean(longint sum, int unsigned w);
      bit neg;
      longint unsigned mag, q;
      longint r;
      neg = sum < 0;
      mag = neg ? longint'(-sum) : longint'(sum);
      q = ((mag << FRACTION_BITS) * 2 + w) / (2 * longint'(w));
      if (q > 64'd8388608) q = 64'd8388608;
      r = neg ? -longint'(q) : longint'(q);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[EST_BITS-1:0];
   endfunction

   // push one sample and work out the window average it produces
   function automatic average_result_type average_sample(logic signed [SAMPLE_BITS-1:0] s);
      average_result_type res;
      longint s0, sum, x, num, d;
      longint unsigned ad, nn, a, r;
      logic [127:0] lhs, rhs;
      int unsigned n, w, iters;
      sample_hist[hist_wr] = longint'(s);
      hist_wr = (hist_wr + 1) % RING_DEPTH;
      if (hist_fill < RING_DEPTH) hist_fill++;
      s0 = hist_at(0);
      if (hist_fill < 2) begin
         res.estimate = rounded_mean(s0, 1);
         res.used = '0;
         res.saved = '0;
         return res;
      end
      d = s0 - hist_at(1);
      ad = d < 0 ? longint'(-d) : longint'(d);
      nn = (ad == 0) ? win_hi_reg : scale_reg / ad;
      if (nn < win_lo_reg) nn = win_lo_reg;
      if (nn > win_hi_reg) nn = win_hi_reg;
      if (nn > hist_fill) nn = hist_fill;
      n = nn;
      sum = s0;
      w = 1;
      iters = 0;
      while (w < n) begin
         w++;
         x = hist_at(w - 1);
         num = x * longint'(w - 1) - sum;
         sum += x;
         iters++;
         a = num < 0 ? longint'(-num) : longint'(num);
         lhs = 128'(a) * 128'(n) * 128'(a);
         r = longint'(sigma_reg) * w * (w - 1);
         rhs = 128'(r) * 128'(r);
         if (lhs < rhs) break;
      end
      res.estimate = rounded_mean(sum, w);
      res.used = iters[ITER_BITS-1:0];
      res.saved = (n > iters) ? WIN_BITS'(n - iters) : '0;
      return res;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // request side: prediction happens when the sample is taken
   always @(posedge clock) begin
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) begin
         expected_averages.push_back(average_sample(req_sample));
         requests_sent++;
      end
   end

   // request driver, changes at the falling edge; holds until taken
   always @(negedge clock) begin
      if (reset || (req_valid && !req_fire)) begin
      end else if (pending_samples.size() > 0 &&
                   (quiet_stretch || $urandom_range(99) >= 7)) begin
         req_valid <= 1'b1;
         req_sample <= pending_samples.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random idling, plus one long hold-off counted here
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= 7);
      end
   end

   // result monitor, compares each field against the oldest expectation
   always @(posedge clock) begin
      average_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_averages.size() == 0) begin
            $display("%0t: unexpected result est=%0d used=%0d saved=%0d", $time,
                     rsp_estimate, rsp_iterations_used, rsp_saved_iterations);
            errors++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_estimate !== want.estimate) begin
               $display("%0t: estimate expected %0d got %0d", $time,
                        want.estimate, rsp_estimate);
               errors++;
            end
            if (rsp_iterations_used !== want.used) begin
               $display("%0t: iterations_used expected %0d got %0d", $time,
                        want.used, rsp_iterations_used);
               errors++;
            end
            if (rsp_saved_iterations !== want.saved) begin
               $display("%0t: saved_iterations expected %0d got %0d", $time,
                        want.saved, rsp_saved_iterations);
               errors++;
            end
         end
      end
   end

   // register write: setup then access; the model copy changes at the write edge
   task automatic write_reg(logic [1:0] index, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({index, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_NOISE_SIGMA: sigma_reg = value[15:0];
         REG_UNIT_SCALE:  scale_reg = value[15:0];
         REG_WINDOW_MIN:  win_lo_reg = value[7:0];
         REG_WINDOW_MAX:  win_hi_reg = value[7:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(int unsigned sigma, int unsigned scale,
                             int unsigned lo, int unsigned hi);
      write_reg(REG_NOISE_SIGMA, sigma);
      write_reg(REG_UNIT_SCALE, scale);
      write_reg(REG_WINDOW_MIN, lo);
      write_reg(REG_WINDOW_MAX, hi);
   endtask

   // wait until every queued sample went in and every average came back
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_averages.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly a slowly drifting level with small noise, which opens wide
   // windows; the rest full-range noise and exact repeats
   function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         drift_level += int'($urandom_range(8)) - 4;
         if (drift_level > 32767) drift_level = 32767;
         if (drift_level < -32768) drift_level = -32768;
         return SAMPLE_BITS'(drift_level);
      end else if (pick < 85) begin
         return SAMPLE_BITS'($urandom());
      end else if (pick < 90) begin
         drift_level = int'($urandom_range(65535)) - 32768;
         return SAMPLE_BITS'(drift_level);
      end else begin
         return SAMPLE_BITS'(drift_level);
      end
   endfunction

   task automatic queue_random(int count);
      repeat (count) pending_samples.push_back(next_sample());
   endtask

   initial begin
      int unsigned sig, scl, lo, hi;
      for (int i = 0; i < RING_DEPTH; i++) sample_hist[i] = 0;
      hist_wr = 0;
      hist_fill = 0;
      sigma_reg = 20;
      scale_reg = 4096;
      win_lo_reg = 4;
      win_hi_reg = 128;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first sample alone, extremes, zero step, full-scale steps
      pending_samples.push_back(-16'sd32768);
      pending_samples.push_back(-16'sd32768);
      pending_samples.push_back(16'sd32767);
      pending_samples.push_back(16'sd32767);
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(-16'sd1);
      pending_samples.push_back(16'sd1);
      for (int i = 0; i < 6; i++) pending_samples.push_back(16'sd100 + 16'(i % 2));
      drain();

      // zero sigma grows to full window; widest division numerator
      set_config(0, 65535, 1, 128);
      repeat (4) pending_samples.push_back(16'sd5);
      pending_samples.push_back(16'sd6);
      drain();

      // maximal sigma, zero unit scale, zero min, max beyond ring depth
      set_config(65535, 0, 0, 255);
      pending_samples.push_back(16'sd7);
      pending_samples.push_back(16'sd7);
      pending_samples.push_back(-16'sd300);
      drain();

      // min above max, then a window of zero
      set_config(20, 4096, 128, 1);
      pending_samples.push_back(16'sd40);
      pending_samples.push_back(16'sd41);
      drain();
      set_config(20, 4096, 0, 0);
      pending_samples.push_back(16'sd41);
      pending_samples.push_back(-16'sd41);
      drain();

      // random phases, each under its own register setting
      set_config(20, 4096, 4, 128);
      queue_random(80);
      drain();
      set_config(0, 65535, 1, 128);
      queue_random(60);
      drain();
      for (int ph = 0; ph < 9; ph++) begin
         sig = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200);
         scl = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(8192);
         lo = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(16);
         hi = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(128);
         set_config(sig, scl, lo, hi);
         queue_random(50);
         drain();
      end

      $display("sent %0d samples, checked %0d averages across directed and random phases",
               requests_sent, results_seen);
      $display("covered full-range samples, zero and huge steps and extreme window settings");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
